[rtl/pbd_pkg.sv]
// Shared types and constants for the push button dimmer control.
package pbd_pkg;

    localparam int LEVEL_MAX_DEF = 127;
    localparam int TICK_W        = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int OUT_LEVEL_W   = 7;
    localparam int LEVEL_EXT_W   = 8;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_DIMMING = 2'd2,
        MODE_MAXED   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_THRESHOLD = 1'b0,
        REG_STEP_INTERVAL  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [TICK_W-1:0] hold_threshold;
        logic [TICK_W-1:0] step_interval;
    } t_cfg;

    typedef struct packed {
        t_mode                  light_mode;
        logic [OUT_LEVEL_W-1:0] light_level;
        logic                   ramp_down;
        logic                   on_notify;
        logic                   off_notify;
        logic                   level_notify;
    } t_result;

endpackage

[rtl/pbd_cfg.sv]
// Configuration register file for hold threshold and step interval.
module pbd_cfg
    import pbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_threshold <= TICK_W'(100);
            r_cfg.step_interval  <= TICK_W'(10);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_HOLD_THRESHOLD: r_cfg.hold_threshold <= i_cfg_wdata;
                REG_STEP_INTERVAL:  r_cfg.step_interval  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/pbd_step.sv]
// Dimmer state registers and the combinational step logic.
module pbd_step
    import pbd_pkg::*;
#(
    parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_button_down,
    input  logic [TICK_W-1:0] i_now_ticks,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    localparam int LW = $clog2(LEVEL_MAX + 1);
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVEL_MAX);

    t_mode             r_mode;
    t_mode             n_mode;
    logic [LW-1:0]     r_level;
    logic [LW-1:0]     n_level;
    logic              r_dir_down;
    logic              n_dir_down;
    logic              r_pressed;
    logic              n_pressed;
    logic [TICK_W-1:0] r_last_time;
    logic [TICK_W-1:0] n_last_time;

    logic [TICK_W-1:0]      elapsed;
    logic                   take_hold;
    logic                   step_due;
    logic [LW-1:0]          step_level;
    logic                   step_dir;
    logic                   on_n;
    logic                   off_n;
    logic [LEVEL_EXT_W-1:0] level_ext;

    assign elapsed   = i_now_ticks - r_last_time;
    assign step_due  = elapsed > i_cfg.step_interval;
    assign take_hold = ((elapsed > i_cfg.hold_threshold) || (r_mode == MODE_DIMMING))
                       && (r_mode != MODE_MAXED);

    always_comb begin
        step_level = r_level;
        step_dir   = r_dir_down;
        if (!r_dir_down) begin
            if (r_level < LVL_TOP) step_level = r_level + LW'(1);
            if (step_level >= LVL_TOP) step_dir = 1'b1;
        end else begin
            if (r_level != '0) step_level = r_level - LW'(1);
            if (step_level == '0) step_dir = 1'b0;
        end
    end

    always_comb begin
        n_mode = r_mode;
        if (i_button_down) begin
            if (take_hold) begin
                n_mode = (r_mode == MODE_OFF) ? MODE_MAXED : MODE_DIMMING;
            end
        end else if (r_pressed) begin
            unique case (r_mode)
                MODE_ON:                            n_mode = MODE_OFF;
                MODE_OFF, MODE_DIMMING, MODE_MAXED: n_mode = MODE_ON;
                default:                            n_mode = MODE_OFF;
            endcase
        end
    end

    always_comb begin
        n_level     = r_level;
        n_dir_down  = r_dir_down;
        n_pressed   = r_pressed;
        n_last_time = r_last_time;
        on_n        = 1'b0;
        off_n       = 1'b0;
        if (i_button_down) begin
            n_pressed = 1'b1;
            if (take_hold) begin
                if (r_mode == MODE_OFF) begin
                    n_level = LVL_TOP;
                    on_n    = 1'b1;
                end else begin
                    if (step_due) begin
                        n_level    = step_level;
                        n_dir_down = step_dir;
                    end
                    n_last_time = i_now_ticks;
                end
            end
        end else begin
            n_pressed   = 1'b0;
            n_last_time = i_now_ticks;
            if (r_pressed) begin
                unique case (r_mode)
                    MODE_DIMMING: n_dir_down = ~r_dir_down;
                    MODE_OFF: begin
                        n_dir_down = 1'b1;
                        on_n       = 1'b1;
                    end
                    MODE_ON: begin
                        n_dir_down = 1'b0;
                        off_n      = 1'b1;
                    end
                    MODE_MAXED: n_dir_down = 1'b1;
                    default:    n_dir_down = r_dir_down;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_level     <= '0;
            r_dir_down  <= 1'b0;
            r_pressed   <= 1'b0;
            r_last_time <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_level     <= n_level;
            r_dir_down  <= n_dir_down;
            r_pressed   <= n_pressed;
            r_last_time <= n_last_time;
        end
    end

    assign level_ext = LEVEL_EXT_W'(n_level);

    always_comb begin
        o_res.light_mode   = n_mode;
        o_res.light_level  = level_ext[OUT_LEVEL_W-1:0];
        o_res.ramp_down    = n_dir_down;
        o_res.on_notify    = on_n;
        o_res.off_notify   = off_n;
        o_res.level_notify = (n_level != r_level);
    end

endmodule

[rtl/push_button_dimmer_control.sv]
// Top level of the single push button dimmer: input stage, step logic, result stage.
// A sample waits in the input register; its result is registered in the output stage.
// Throughput: one sample per cycle while i_ready is high; the update is one compare/subtract.
// While a result waits for i_ready, an empty input register still takes one new sample.
// Reset (synchronous, i_rst_n low): mode off, level 0, ramp up, button released,
// last time 0, hold threshold 100, step interval 10, both stages empty.
module push_button_dimmer_control
    import pbd_pkg::*;
#(
    parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_button_down,
    input  logic [TICK_W-1:0]      i_now_ticks,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_light_mode,
    output logic [OUT_LEVEL_W-1:0] o_light_level,
    output logic                   o_ramp_down,
    output logic                   o_on_notify,
    output logic                   o_off_notify,
    output logic                   o_level_notify,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg              cfg;
    t_result           step_res;
    logic              advance;
    logic              r_in_valid;
    logic              r_button_down;
    logic [TICK_W-1:0] r_now_ticks;
    logic              r_out_valid;
    t_result           r_res;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    pbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pbd_step #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_button_down (r_button_down),
        .i_now_ticks   (r_now_ticks),
        .i_cfg         (cfg),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_button_down <= i_button_down;
            r_now_ticks   <= i_now_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_light_mode   = r_res.light_mode;
    assign o_light_level  = r_res.light_level;
    assign o_ramp_down    = r_res.ramp_down;
    assign o_on_notify    = r_res.on_notify;
    assign o_off_notify   = r_res.off_notify;
    assign o_level_notify = r_res.level_notify;

    localparam logic [LEVEL_EXT_W-1:0] LVL_TOP_EXT = LEVEL_EXT_W'(LEVEL_MAX);

    a_notify_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_on_notify && o_off_notify))
        else $error("on and off notify both set");

    a_on_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_on_notify) |->
            (o_light_mode == MODE_ON || o_light_mode == MODE_MAXED))
        else $error("on notify with light not on");

    a_off_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_off_notify) |-> (o_light_mode == MODE_OFF && !o_ramp_down))
        else $error("off notify with wrong mode or ramp");

    a_maxed_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_light_mode == MODE_MAXED) |->
            (o_light_level == LVL_TOP_EXT[OUT_LEVEL_W-1:0]))
        else $error("maxed light below full level");

    a_no_result_without_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && (!o_valid || i_ready)) |=> !o_valid)
        else $error("result without a sample");

endmodule

[verif/dimmer_result_check.sv]
// Result checker for the push button dimmer: tracks its own copy of the dimmer state.
module dimmer_result_check
    import pbd_pkg::*;
#(
    parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic                   i_button_down,
    input  logic [TICK_W-1:0]      i_now_ticks,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [1:0]             i_light_mode,
    input  logic [OUT_LEVEL_W-1:0] i_light_level,
    input  logic                   i_ramp_down,
    input  logic                   i_on_notify,
    input  logic                   i_off_notify,
    input  logic                   i_level_notify,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    t_mode                  mode;
    logic [LEVEL_EXT_W-1:0] level;
    logic                   ramp_dn;
    logic                   held;
    logic [TICK_W-1:0]      last_tick;
    logic [TICK_W-1:0]      hold_th;
    logic [TICK_W-1:0]      step_iv;
    t_result                expected_lights[$];
    int                     fails = 0;

    assign o_fail_count = fails;

    task automatic step_dimmer(input logic btn, input logic [TICK_W-1:0] now,
                               output t_result res);
        logic [TICK_W-1:0]      elapsed;
        logic [LEVEL_EXT_W-1:0] prior;
        elapsed = now - last_tick;
        prior   = level;
        res     = '0;
        if (btn) begin
            held = 1'b1;
            if ((elapsed > hold_th || mode == MODE_DIMMING) && mode != MODE_MAXED) begin
                if (mode == MODE_OFF) begin
                    mode          = MODE_MAXED;
                    level         = LEVEL_EXT_W'(LEVEL_MAX);
                    res.on_notify = 1'b1;
                end else begin
                    mode = MODE_DIMMING;
                    if (elapsed > step_iv) begin
                        if (!ramp_dn) begin
                            if (level < LEVEL_MAX) level = level + 1'b1;
                            if (level >= LEVEL_MAX) ramp_dn = 1'b1;
                        end else begin
                            if (level > 0) level = level - 1'b1;
                            if (level == 0) ramp_dn = 1'b0;
                        end
                    end
                    last_tick = now;
                end
            end
        end else begin
            if (held) begin
                held = 1'b0;
                case (mode)
                    MODE_DIMMING: begin
                        mode    = MODE_ON;
                        ramp_dn = ~ramp_dn;
                    end
                    MODE_OFF: begin
                        mode          = MODE_ON;
                        ramp_dn       = 1'b1;
                        res.on_notify = 1'b1;
                    end
                    MODE_ON: begin
                        mode           = MODE_OFF;
                        ramp_dn        = 1'b0;
                        res.off_notify = 1'b1;
                    end
                    default: begin
                        mode    = MODE_ON;
                        ramp_dn = 1'b1;
                    end
                endcase
            end
            last_tick = now;
        end
        res.light_mode   = mode;
        res.light_level  = level[OUT_LEVEL_W-1:0];
        res.ramp_down    = ramp_dn;
        res.level_notify = (level != prior);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            mode      = MODE_OFF;
            level     = '0;
            ramp_dn   = 1'b0;
            held      = 1'b0;
            last_tick = '0;
            hold_th   = 32'd100;
            step_iv   = 32'd10;
            expected_lights.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_HOLD_THRESHOLD: hold_th = i_cfg_wdata;
                    REG_STEP_INTERVAL:  step_iv = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.light_mode   = t_mode'(i_light_mode);
                got.light_level  = i_light_level;
                got.ramp_down    = i_ramp_down;
                got.on_notify    = i_on_notify;
                got.off_notify   = i_off_notify;
                got.level_notify = i_level_notify;
                if (expected_lights.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with no sample pending: mode %0d level %0d",
                                 $time, got.light_mode, got.light_level);
                end else begin
                    want = expected_lights.pop_front();
                    if (got.light_mode !== want.light_mode ||
                        got.light_level !== want.light_level ||
                        got.ramp_down !== want.ramp_down ||
                        got.on_notify !== want.on_notify ||
                        got.off_notify !== want.off_notify ||
                        got.level_notify !== want.level_notify) begin
                        fails++;
                        if (fails <= 10) begin
                            $write("%0t: mismatch: expected mode %0d level %0d down %b",
                                   $time, want.light_mode, want.light_level,
                                   want.ramp_down);
                            $write(" on %b off %b chg %b,", want.on_notify,
                                   want.off_notify, want.level_notify);
                            $write(" got mode %0d level %0d down %b", got.light_mode,
                                   got.light_level, got.ramp_down);
                            $display(" on %b off %b chg %b", got.on_notify,
                                     got.off_notify, got.level_notify);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_dimmer(i_button_down, i_now_ticks, want);
                expected_lights.push_back(want);
            end
        end
        o_pending <= expected_lights.size();
    end

endmodule

[verif/push_button_dimmer_control_tb.sv]
// Testbench top for the push button dimmer: stimulus, receiver stalls, watchdog, verdict.
module push_button_dimmer_control_tb;
    import pbd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   button_down;
    logic [TICK_W-1:0]      now_ticks;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             light_mode;
    logic [OUT_LEVEL_W-1:0] light_level;
    logic                   ramp_down;
    logic                   on_notify;
    logic                   off_notify;
    logic                   level_notify;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int                     fail_count;
    int                     pending;

    logic                   idle_en = 1'b1;
    logic                   tail = 1'b0;
    int                     ready_hold = 0;
    logic [TICK_W-1:0]      tick_now;

    push_button_dimmer_control u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_button_down  (button_down),
        .i_now_ticks    (now_ticks),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_light_mode   (light_mode),
        .o_light_level  (light_level),
        .o_ramp_down    (ramp_down),
        .o_on_notify    (on_notify),
        .o_off_notify   (off_notify),
        .o_level_notify (level_notify),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata)
    );

    dimmer_result_check u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_button_down  (button_down),
        .i_now_ticks    (now_ticks),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_light_mode   (light_mode),
        .i_light_level  (light_level),
        .i_ramp_down    (ramp_down),
        .i_on_notify    (on_notify),
        .i_off_notify   (off_notify),
        .i_level_notify (level_notify),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic push_sample(input logic btn, input logic [TICK_W-1:0] ts);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        button_down <= btn;
        now_ticks   <= ts;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(input logic [TICK_W-1:0] thr, input logic [TICK_W-1:0] gap);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_HOLD_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_idx   <= REG_STEP_INTERVAL;
        cfg_wdata <= gap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_presses(input int count);
        int sent;
        int len;
        int rel;
        int spread;
        int k;
        sent = 0;
        while (sent < count) begin
            if (!tail) idle_en = ($urandom_range(0, 3) != 0);
            spread = $urandom_range(1, 25);
            if ($urandom_range(0, 9) == 0) begin
                tick_now = $urandom;
                push_sample(1'($urandom_range(0, 1)), tick_now);
                sent++;
            end else begin
                case ($urandom_range(0, 4))
                    0, 1:    len = $urandom_range(1, 3);
                    2, 3:    len = $urandom_range(4, 40);
                    default: len = $urandom_range(41, 300);
                endcase
                rel = $urandom_range(1, 3);
                for (k = 0; k < len + rel; k++) begin
                    tick_now += $urandom_range(0, spread);
                    push_sample(k < len, tick_now);
                end
                sent += len + rel;
            end
        end
    endtask

    initial begin : receiver
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (ready_hold > 0) begin
                ready_hold--;
                out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        button_down <= 1'b0;
        now_ticks   <= '0;
        cfg_we      <= 1'b0;
        cfg_idx     <= REG_HOLD_THRESHOLD;
        cfg_wdata   <= '0;
        tick_now    = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_sample(1'b0, 32'h0000_0000);
        push_sample(1'b1, 32'h0000_0064);
        push_sample(1'b0, 32'h0000_0065);
        push_sample(1'b1, 32'h0000_0096);
        push_sample(1'b0, 32'h0000_00A0);
        push_sample(1'b1, 32'h0000_0105);
        push_sample(1'b1, 32'hFFFF_FFFF);
        push_sample(1'b0, 32'h0000_0005);
        push_sample(1'b1, 32'h0000_006A);
        push_sample(1'b1, 32'h0000_0074);
        push_sample(1'b1, 32'h0000_007F);
        push_sample(1'b0, 32'h0000_0080);
        push_sample(1'b1, 32'h0000_00E5);
        push_sample(1'b1, 32'h0000_00F0);
        push_sample(1'b1, 32'h0000_00FB);
        push_sample(1'b0, 32'hFFFF_FFF0);
        push_sample(1'b1, 32'h0000_0060);
        push_sample(1'b0, 32'h8000_0000);
        push_sample(1'b1, 32'h8000_0000);
        push_sample(1'b0, 32'h8000_0001);
        settle();

        program_limits(32'h0000_0000, 32'h0000_0000);
        run_presses(220);
        settle();

        program_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_presses(220);
        settle();

        program_limits(32'd20, 32'd1);
        // hold the result side off long enough to back up the input side
        ready_hold = 300;
        run_presses(220);
        settle();

        program_limits($urandom_range(1, 150), $urandom_range(2, 12));
        run_presses(220);
        settle();

        program_limits(32'd100, 32'd10);
        tail    = 1'b1;
        idle_en = 1'b0;
        run_presses(220);
        settle();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/pbd_pkg.sv
rtl/pbd_cfg.sv
rtl/pbd_step.sv
rtl/push_button_dimmer_control.sv
verif/dimmer_result_check.sv
verif/push_button_dimmer_control_tb.sv
